/* hw/rtl/tst_pkg.sv */
`default_nettype none
package tst_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W = (SLOT_W > 4) ? SLOT_W : 4;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_SLOT = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [46:0] now_ms;
    logic [46:0] delay_ms;
    logic [3:0]  slot_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned_slot;
    logic [47:0] earliest_ms;
    logic        none_pending;
  } rsp_t;

  // search record walking down the row of slot cells
  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] deadline;
    logic [3:0]  slot_id;
    logic        placed;
    logic        hit;
    logic [3:0]  assigned;
    logic        found;
    logic [47:0] best;
  } rec_t;

endpackage
`default_nettype wire

/* hw/rtl/tst_cell.sv */
`default_nettype none
module tst_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [tst_pkg::SLOT_W-1:0] cell_index,
  input  logic                      rec_in_valid,
  input  tst_pkg::rec_t             rec_in,
  output logic                      rec_out_valid,
  output tst_pkg::rec_t             rec_out
);
  import tst_pkg::*;

  logic        active;
  logic [47:0] deadline;
  logic        active_next;
  logic [47:0] deadline_next;
  rec_t        rec_next;
  logic        id_match;

  assign id_match = (CMP_W'(rec_in.slot_id) == CMP_W'(cell_index));

  always_comb begin
    active_next   = active;
    deadline_next = deadline;
    rec_next      = rec_in;
    if (rec_in_valid) begin
      if (rec_in.mode == MODE_ADD && !rec_in.placed && !active) begin
        active_next       = 1'b1;
        deadline_next     = rec_in.deadline;
        rec_next.placed   = 1'b1;
        rec_next.assigned = 4'(cell_index);
      end
      if (rec_in.mode == MODE_CANCEL && id_match && active) begin
        active_next  = 1'b0;
        rec_next.hit = 1'b1;
      end
      // minimum over the post-update slot state
      if (active_next) begin
        if (!rec_in.found || deadline_next < rec_in.best) begin
          rec_next.best = deadline_next;
        end
        rec_next.found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      rec_out_valid <= 1'b0;
    end else begin
      active        <= active_next;
      rec_out_valid <= rec_in_valid;
    end
    deadline <= deadline_next;
    rec_out  <= rec_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/timer_slot_table.sv */
`default_nettype none
// Timer slot table with earliest-deadline search. Each slot lives in its own cell of a
// row of SLOTS cells; an accepted transaction becomes a search record that visits one
// cell per cycle, allocating the lowest free slot on add, freeing the named slot on
// cancel, and folding the smallest active deadline as it goes. One transaction is in
// the row at a time: the request is registered, passes through each cell in turn, the
// result is formed in the finish register and then handed to the output register once
// rsp_stall allows, and only then can the next request be accepted. A finished result
// may wait in the output register while the next transaction runs.
module timer_slot_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  tst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output tst_pkg::rsp_t rsp
);
  import tst_pkg::*;

  logic       busy;
  logic       entry_valid;
  rec_t       entry_rec;
  logic       link_valid [0:SLOTS];
  rec_t       link_rec   [0:SLOTS];
  logic       fin_valid;
  rsp_t       fin;
  rsp_t       fin_next;
  rec_t       last;
  logic       req_take;
  logic       fin_move;

  assign req_stall = busy;
  assign req_take  = req_valid && !busy;
  assign fin_move  = fin_valid && (!rsp_valid || !rsp_stall);

  assign link_valid[0] = entry_valid;
  assign link_rec[0]   = entry_rec;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tst_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cell_index   (SLOT_W'(i)),
      .rec_in_valid (link_valid[i]),
      .rec_in       (link_rec[i]),
      .rec_out_valid(link_valid[i+1]),
      .rec_out      (link_rec[i+1])
    );
  end

  assign last = link_rec[SLOTS];

  always_comb begin
    fin_next.status = STATUS_OK;
    if (last.mode == MODE_ADD && !last.placed) begin
      fin_next.status = STATUS_FULL;
    end else if (last.mode == MODE_CANCEL && !last.hit) begin
      fin_next.status = STATUS_BAD_SLOT;
    end
    fin_next.assigned_slot = last.placed ? last.assigned : 4'd0;
    fin_next.earliest_ms   = last.found ? last.best : 48'd0;
    fin_next.none_pending  = !last.found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      entry_valid <= 1'b0;
      fin_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      entry_valid <= req_take;
      if (req_take) begin
        busy <= 1'b1;
      end else if (fin_move) begin
        busy <= 1'b0;
      end
      if (link_valid[SLOTS]) begin
        fin_valid <= 1'b1;
      end else if (fin_move) begin
        fin_valid <= 1'b0;
      end
      if (fin_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_take) begin
      entry_rec.mode     <= req.mode;
      entry_rec.deadline <= {1'b0, req.now_ms} + {1'b0, req.delay_ms};
      entry_rec.slot_id  <= req.slot_id;
      entry_rec.placed   <= 1'b0;
      entry_rec.hit      <= 1'b0;
      entry_rec.assigned <= 4'd0;
      entry_rec.found    <= 1'b0;
      entry_rec.best     <= 48'd0;
    end
    if (link_valid[SLOTS]) begin
      fin <= fin_next;
    end
    if (fin_move) begin
      rsp <= fin;
    end
  end

`ifndef NO_ASSERTIONS
  logic [SLOTS+1:0] token_bits;

  always_comb begin
    for (int k = 0; k <= SLOTS; k++) begin
      token_bits[k] = link_valid[k];
    end
    token_bits[SLOTS+1] = fin_valid;
  end

  a_one_token : assert property (@(posedge clk) disable iff (rst)
    $onehot0(token_bits))
    else $error("more than one transaction in the slot row");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    !busy |-> token_bits == '0)
    else $error("transaction in flight while idle");

  a_none_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.none_pending |-> rsp.earliest_ms == 48'd0)
    else $error("earliest deadline nonzero with nothing pending");

  a_full_pending : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_FULL |-> !rsp.none_pending)
    else $error("table full reported with no active slot");
`endif

endmodule
`default_nettype wire
